### rtl/rrwlt_pkg.sv
`default_nettype none

package rrwlt_pkg;

  localparam int NUM_SLOTS_DEF   = 361;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int OP_W  = 3;
  localparam int DEG_W = 9;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_SET_DEGREE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_LOCK    = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_REQ    = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_RETRY  = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE_CANCEL = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_UNLOCK  = 3'd5;
  localparam logic [OP_W-1:0] OP_WRITE_UNLOCK = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED       = 3'd7;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_BUSY  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_COUNT = 2'd3;

  typedef logic [2:0] act_t;

  localparam act_t ACT_NONE   = 3'd0;
  localparam act_t ACT_INC_R  = 3'd1;
  localparam act_t ACT_INC_W  = 3'd2;
  localparam act_t ACT_INC_WW = 3'd3;
  localparam act_t ACT_DEC_R  = 3'd4;
  localparam act_t ACT_DEC_W  = 3'd5;
  localparam act_t ACT_DEC_WW = 3'd6;
  localparam act_t ACT_RETRY  = 3'd7;

  typedef struct packed {
    logic rd;
    logic upd;
    logic clr;
    act_t act;
  } slot_ctrl_t;

  typedef struct packed {
    logic r_zero;
    logic w_zero;
    logic ww_zero;
    logic r_max;
    logic ww_max;
  } slot_flags_t;

  typedef struct packed {
    logic r_zero;
    logic w_zero;
    logic ww_zero;
    logic r_max;
    logic ww_max;
    logic rw_nz;
    logic www_nz;
  } acc_t;

endpackage

`default_nettype wire

### rtl/rrwlt_ifs.sv
`default_nettype none

interface rrwlt_req_if import rrwlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DEG_W-1:0]  center_degree;
  logic [DEG_W-1:0]  range_width;

  modport source (output valid, output opcode, output center_degree, output range_width,
                  input ready);
  modport sink (input valid, input opcode, input center_degree, input range_width,
                output ready);
endinterface

interface rrwlt_rsp_if import rrwlt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

### rtl/range_reader_writer_lock_table.sv
// channel | dir | fields                               | handshake
// req     | in  | opcode, center_degree, range_width   | valid/ready
// rsp     | out | status                               | valid/ready
//
// set degree, a bad range or the unused opcode: result word in the cycle after accept
// other requests over n = 2*width+1 slots: a check pass over the slots, then an update
// pass when counters change, then the result is loaded once the output register is free;
// the slot memory takes one slot per cycle in each pass
// after reset a clearing pass over all NUM_SLOTS slots zeroes the memory, req.ready low
// a result word waiting in the output register blocks the next request only when held
`default_nettype none

module range_reader_writer_lock_table import rrwlt_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rrwlt_req_if.sink    req,
  rrwlt_rsp_if.source  rsp
);

  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam int CMP_W  = (ADDR_W > DEG_W + 1) ? ADDR_W : DEG_W + 1;
  localparam logic [CMP_W-1:0] LAST = CMP_W'(NUM_SLOTS - 1);

  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_CHECK      = 3'd2;
  localparam logic [2:0] S_CHECK_END  = 3'd3;
  localparam logic [2:0] S_UPDATE     = 3'd4;
  localparam logic [2:0] S_UPDATE_END = 3'd5;
  localparam logic [2:0] S_DONE       = 3'd6;

  logic [2:0]       state;
  logic [CMP_W-1:0] ptr;
  logic [CMP_W-1:0] lo_r;
  logic [CMP_W-1:0] hi_r;
  logic [OP_W-1:0]  op_r;
  logic             deg_ok;
  logic [DEG_W-1:0] cur_deg;
  logic             chk_vld;
  acc_t             acc;
  act_t             act_r;
  logic [ST_W-1:0]  st_r;
  logic             rsp_valid;
  logic [ST_W-1:0]  rsp_status;

  logic [CMP_W-1:0] c_ext, w_ext, sum, lo_in, deg_ext;
  logic             bad, deg_in, accept, out_free, rsp_set;
  slot_ctrl_t       ctrl;
  slot_flags_t      fl;
  acc_t             now_f, merged;
  act_t             dec_act;
  logic [ST_W-1:0]  dec_st;

  assign c_ext   = CMP_W'(req.center_degree);
  assign w_ext   = CMP_W'(req.range_width);
  assign deg_ext = CMP_W'(cur_deg);
  assign sum     = c_ext + w_ext;
  assign lo_in   = c_ext - w_ext;
  assign bad     = (req.opcode == OP_UNUSED) || (w_ext > c_ext) || (sum > LAST);
  assign deg_in  = (deg_ext >= lo_in) && (deg_ext <= sum);

  assign out_free   = !rsp_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign accept     = req.valid && req.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp_set    = (accept && ((req.opcode == OP_SET_DEGREE) || bad)) ||
                      ((state == S_DONE) && out_free);

  assign ctrl.rd  = (state == S_CHECK) || (state == S_UPDATE);
  assign ctrl.upd = (state == S_UPDATE);
  assign ctrl.clr = (state == S_CLEAR);
  assign ctrl.act = act_r;

  rrwlt_table #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .addr  (ptr[ADDR_W-1:0]),
    .flags (fl)
  );

  assign now_f.r_zero  = fl.r_zero;
  assign now_f.w_zero  = fl.w_zero;
  assign now_f.ww_zero = fl.ww_zero;
  assign now_f.r_max   = fl.r_max;
  assign now_f.ww_max  = fl.ww_max;
  assign now_f.rw_nz   = !fl.r_zero || !fl.w_zero;
  assign now_f.www_nz  = !fl.w_zero || !fl.ww_zero;
  assign merged        = acc_t'(acc | now_f);

  always_comb begin
    dec_act = ACT_NONE;
    dec_st  = ST_OK;
    unique case (op_r)
      OP_READ_LOCK: begin
        if (!deg_ok || merged.www_nz) begin
          dec_st = ST_BUSY;
        end else if (merged.r_max) begin
          dec_st = ST_COUNT;
        end else begin
          dec_act = ACT_INC_R;
        end
      end
      OP_WRITE_REQ: begin
        if (merged.ww_max) begin
          dec_st = ST_COUNT;
        end else if (deg_ok && !merged.rw_nz) begin
          dec_act = ACT_INC_W;
        end else begin
          dec_act = ACT_INC_WW;
          dec_st  = ST_BUSY;
        end
      end
      OP_WRITE_RETRY: begin
        if (!deg_ok || merged.rw_nz) begin
          dec_st = ST_BUSY;
        end else if (merged.ww_zero) begin
          dec_st = ST_COUNT;
        end else begin
          dec_act = ACT_RETRY;
        end
      end
      OP_WRITE_CANCEL: begin
        if (merged.ww_zero) begin
          dec_st = ST_COUNT;
        end else begin
          dec_act = ACT_DEC_WW;
        end
      end
      OP_READ_UNLOCK: begin
        if (merged.r_zero) begin
          dec_st = ST_COUNT;
        end else begin
          dec_act = ACT_DEC_R;
        end
      end
      OP_WRITE_UNLOCK: begin
        if (merged.w_zero) begin
          dec_st = ST_COUNT;
        end else begin
          dec_act = ACT_DEC_W;
        end
      end
      default: begin
        dec_st = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      rsp_valid <= 1'b0;
      cur_deg   <= '0;
      chk_vld   <= 1'b0;
    end else begin
      chk_vld <= (state == S_CHECK);
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (ptr == LAST) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + CMP_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.opcode == OP_SET_DEGREE) begin
              if (c_ext <= LAST) begin
                cur_deg    <= req.center_degree;
                rsp_status <= ST_OK;
              end else begin
                rsp_status <= ST_RANGE;
              end
            end else if (bad) begin
              rsp_status <= ST_RANGE;
            end else begin
              op_r   <= req.opcode;
              lo_r   <= lo_in;
              hi_r   <= sum;
              ptr    <= lo_in;
              deg_ok <= deg_in;
              acc    <= '0;
              state  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (chk_vld) begin
            acc <= merged;
          end
          if (ptr == hi_r) begin
            state <= S_CHECK_END;
          end else begin
            ptr <= ptr + CMP_W'(1);
          end
        end
        S_CHECK_END: begin
          st_r  <= dec_st;
          act_r <= dec_act;
          if (dec_act != ACT_NONE) begin
            ptr   <= lo_r;
            state <= S_UPDATE;
          end else begin
            state <= S_DONE;
          end
        end
        S_UPDATE: begin
          if (ptr == hi_r) begin
            state <= S_UPDATE_END;
          end else begin
            ptr <= ptr + CMP_W'(1);
          end
        end
        S_UPDATE_END: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_status <= st_r;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK || state == S_UPDATE) |-> (ptr >= lo_r && ptr <= hi_r && hi_r <= LAST))
    else $error("slot pointer left the request range");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (rsp_valid && state == S_IDLE && rsp_status == $past(st_r)))
    else $error("finished request did not produce its word");

  a_update_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && $past(state) != S_UPDATE) |-> ($past(state) == S_CHECK_END))
    else $error("update pass entered without a check pass");

  a_update_has_action: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE || state == S_UPDATE_END) |-> (act_r != ACT_NONE))
    else $error("update pass with no counter action");

endmodule

`default_nettype wire

### rtl/rrwlt_table.sv
`default_nettype none

module rrwlt_table import rrwlt_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  slot_ctrl_t                   ctrl,
  input  logic [$clog2(NUM_SLOTS)-1:0] addr,
  output slot_flags_t                  flags
);

  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam int CW     = COUNT_WIDTH;
  localparam int WORD_W = 3 * CW;

  logic [WORD_W-1:0] mem [NUM_SLOTS];
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] addr_q;
  logic              upd_q;
  act_t              act_q;

  logic [CW-1:0] r, w, ww;
  logic [CW-1:0] r_new, w_new, ww_new;
  logic [CW-1:0] one;

  assign one = CW'(1);
  assign r   = rdata[CW-1:0];
  assign w   = rdata[2*CW-1:CW];
  assign ww  = rdata[3*CW-1:2*CW];

  assign flags.r_zero  = (r == '0);
  assign flags.w_zero  = (w == '0);
  assign flags.ww_zero = (ww == '0);
  assign flags.r_max   = (r == '1);
  assign flags.ww_max  = (ww == '1);

  always_comb begin
    r_new  = r;
    w_new  = w;
    ww_new = ww;
    unique case (act_q)
      ACT_INC_R:  r_new  = r + one;
      ACT_INC_W:  w_new  = w + one;
      ACT_INC_WW: ww_new = ww + one;
      ACT_DEC_R:  r_new  = r - one;
      ACT_DEC_W:  w_new  = w - one;
      ACT_DEC_WW: ww_new = ww - one;
      ACT_RETRY: begin
        ww_new = ww - one;
        w_new  = w + one;
      end
      default: begin
        r_new = r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rdata <= mem[addr];
    end
    addr_q <= addr;
    act_q  <= ctrl.act;
    if (ctrl.clr) begin
      mem[addr] <= '0;
    end else if (upd_q) begin
      mem[addr_q] <= {ww_new, w_new, r_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_q <= 1'b0;
    end else begin
      upd_q <= ctrl.rd && ctrl.upd;
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top import rrwlt_pkg::*; ();

  localparam int LAST_SLOT    = NUM_SLOTS_DEF - 1;
  localparam int COUNT_MAX    = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 800;
  localparam logic [DEG_W-1:0] BURST_SLOT = 9'd100;

  typedef enum int {TBL_RD, TBL_WR, TBL_WT} table_e;

  class lock_status_board;
    logic [COUNT_WIDTH_DEF-1:0] cnt [3][NUM_SLOTS_DEF];
    logic [DEG_W-1:0]           degree;
    logic [ST_W-1:0]            status_due [$];
    int                         errors;

    function new();
      for (int t = 0; t < 3; t++) begin
        for (int d = 0; d < NUM_SLOTS_DEF; d++) begin
          cnt[t][d] = '0;
        end
      end
      degree = '0;
      errors = 0;
    endfunction

    function bit degree_in(int lo, int hi);
      return int'(degree) >= lo && int'(degree) <= hi;
    endfunction

    function bit any_at(table_e t, int v, int lo, int hi);
      for (int d = lo; d <= hi; d++) begin
        if (int'(cnt[t][d]) == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit nonzero_in(table_e t, int lo, int hi);
      for (int d = lo; d <= hi; d++) begin
        if (cnt[t][d] != '0) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void shift(table_e t, int lo, int hi, bit up);
      for (int d = lo; d <= hi; d++) begin
        cnt[t][d] = up ? cnt[t][d] + 1'b1 : cnt[t][d] - 1'b1;
      end
    endfunction

    function logic [ST_W-1:0] release_range(table_e t, int lo, int hi);
      if (any_at(t, 0, lo, hi)) return ST_COUNT;
      shift(t, lo, hi, 1'b0);
      return ST_OK;
    endfunction

    function logic [ST_W-1:0] resolve_status(logic [OP_W-1:0] op, logic [DEG_W-1:0] c,
                                             logic [DEG_W-1:0] w);
      int ci;
      int wi;
      int lo;
      int hi;
      logic [ST_W-1:0] st;
      ci = int'(c);
      wi = int'(w);
      if (op == OP_SET_DEGREE) begin
        if (ci <= LAST_SLOT) begin
          degree = c;
          return ST_OK;
        end
        return ST_RANGE;
      end
      if (op == OP_UNUSED || wi > ci || ci + wi > LAST_SLOT) return ST_RANGE;
      lo = ci - wi;
      hi = ci + wi;
      case (op)
        OP_READ_LOCK: begin
          if (!degree_in(lo, hi) || nonzero_in(TBL_WR, lo, hi) || nonzero_in(TBL_WT, lo, hi)) begin
            st = ST_BUSY;
          end else if (any_at(TBL_RD, COUNT_MAX, lo, hi)) begin
            st = ST_COUNT;
          end else begin
            shift(TBL_RD, lo, hi, 1'b1);
            st = ST_OK;
          end
        end
        OP_WRITE_REQ: begin
          if (any_at(TBL_WT, COUNT_MAX, lo, hi)) begin
            st = ST_COUNT;
          end else if (degree_in(lo, hi) && !nonzero_in(TBL_RD, lo, hi) &&
                       !nonzero_in(TBL_WR, lo, hi)) begin
            shift(TBL_WR, lo, hi, 1'b1);
            st = ST_OK;
          end else begin
            shift(TBL_WT, lo, hi, 1'b1);
            st = ST_BUSY;
          end
        end
        OP_WRITE_RETRY: begin
          if (!degree_in(lo, hi) || nonzero_in(TBL_RD, lo, hi) || nonzero_in(TBL_WR, lo, hi)) begin
            st = ST_BUSY;
          end else if (any_at(TBL_WT, 0, lo, hi)) begin
            st = ST_COUNT;
          end else begin
            shift(TBL_WT, lo, hi, 1'b0);
            shift(TBL_WR, lo, hi, 1'b1);
            st = ST_OK;
          end
        end
        OP_WRITE_CANCEL: st = release_range(TBL_WT, lo, hi);
        OP_READ_UNLOCK:  st = release_range(TBL_RD, lo, hi);
        default:         st = release_range(TBL_WR, lo, hi);
      endcase
      return st;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [DEG_W-1:0] c, logic [DEG_W-1:0] w);
      status_due.push_back(resolve_status(op, c, w));
    endfunction

    function void check_status(logic [ST_W-1:0] got);
      logic [ST_W-1:0] want;
      if (status_due.size() == 0) begin
        $error("result word with none due: status actual %0d", got);
        errors++;
        return;
      end
      want = status_due.pop_front();
      if (got !== want) begin
        $error("status mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rrwlt_req_if req_if ();
  rrwlt_rsp_if rsp_if ();

  range_reader_writer_lock_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  lock_status_board board;
  int send_idle;
  int recv_idle;
  bit hold_rsp;
  int quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        board.note_request(req_if.opcode, req_if.center_degree, req_if.range_width);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        board.check_status(rsp_if.status);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("** range_reader_writer_lock_table: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [DEG_W-1:0] c, logic [DEG_W-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= op;
    req_if.center_degree <= c;
    req_if.range_width   <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic run_random(int n);
    int pick;
    int c;
    int w;
    int off;
    logic [OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        op = OP_SET_DEGREE;
        c  = ($urandom_range(9) == 0) ? $urandom_range(511, 361) : $urandom_range(LAST_SLOT, 0);
        w  = $urandom_range(511, 0);
      end else if (pick < 20) begin
        op = OP_W'($urandom_range(7, 0));
        c  = $urandom_range(511, 0);
        w  = $urandom_range(511, 0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 25)      op = OP_READ_LOCK;
        else if (pick < 45) op = OP_WRITE_REQ;
        else if (pick < 60) op = OP_WRITE_RETRY;
        else if (pick < 70) op = OP_WRITE_CANCEL;
        else if (pick < 85) op = OP_READ_UNLOCK;
        else                op = OP_WRITE_UNLOCK;
        w   = ($urandom_range(19) == 0) ? $urandom_range(60, 8) : $urandom_range(7, 0);
        off = $urandom_range(2 * w, 0);
        // keep the device degree inside the range most of the time
        c   = int'(board.degree) + off - w;
        if (c < 0) c = 0;
        if (c > LAST_SLOT) c = LAST_SLOT;
      end
      send_word(op, c[DEG_W-1:0], w[DEG_W-1:0]);
    end
  endtask

  initial begin
    board = new();
    send_idle = 0;
    recv_idle = 0;
    hold_rsp  = 1'b0;
    rst                  <= 1'b1;
    req_if.valid         <= 1'b0;
    req_if.opcode        <= OP_SET_DEGREE;
    req_if.center_degree <= '0;
    req_if.range_width   <= '0;
    rsp_if.ready         <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle = 8;
    recv_idle = 75;
    send_word(OP_SET_DEGREE, 511, 0);
    send_word(OP_SET_DEGREE, 361, 0);
    send_word(OP_UNUSED, 10, 2);
    send_word(OP_READ_LOCK, 0, 0);
    send_word(OP_READ_LOCK, 360, 1);
    send_word(OP_READ_LOCK, 0, 1);
    send_word(OP_READ_LOCK, 180, 180);
    send_word(OP_WRITE_REQ, 0, 0);
    send_word(OP_READ_LOCK, 5, 5);
    send_word(OP_READ_UNLOCK, 180, 180);
    send_word(OP_READ_UNLOCK, 0, 0);
    send_word(OP_READ_UNLOCK, 0, 0);
    send_word(OP_WRITE_RETRY, 0, 0);
    send_word(OP_WRITE_RETRY, 0, 0);
    send_word(OP_WRITE_UNLOCK, 0, 0);
    send_word(OP_WRITE_UNLOCK, 0, 0);
    send_word(OP_WRITE_CANCEL, 0, 0);
    send_word(OP_WRITE_REQ, 0, 0);
    send_word(OP_WRITE_UNLOCK, 0, 0);
    send_word(OP_SET_DEGREE, 360, 511);
    send_word(OP_READ_LOCK, 0, 0);
    send_word(OP_WRITE_RETRY, 200, 5);
    send_word(OP_WRITE_REQ, 355, 5);
    send_word(OP_WRITE_UNLOCK, 355, 5);
    send_word(OP_WRITE_REQ, 511, 0);
    send_word(OP_WRITE_REQ, 360, 360);
    send_word(OP_WRITE_RETRY, 360, 0);

    // drive one slot to reader overflow
    send_word(OP_SET_DEGREE, BURST_SLOT, 0);
    repeat (COUNT_MAX + 1) send_word(OP_READ_LOCK, BURST_SLOT, 0);
    send_word(OP_SET_DEGREE, 250, 0);
    run_random(55);

    send_idle = 75;
    recv_idle = 8;
    run_random(55);

    send_idle = 0;
    recv_idle = 0;
    hold_rsp  = 1'b1;
    run_random(55);

    req_if.valid <= 1'b0;
    while (board.status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("** range_reader_writer_lock_table: PASSED **");
    end else begin
      $display("** range_reader_writer_lock_table: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
